[rtl/core/nsf_pkg.sv]
`default_nettype none

package nsf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PATTERN = 16;
    localparam int DEF_COLUMN_BITS = 16;

    // Fixed field widths
    localparam int LEN_W    = 5;
    localparam int OUT_COL_W = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 64;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;
    localparam logic [1:0] REG_IGNORE_CASE    = 2'd3;

    // Controls shared by every history cell
    typedef struct packed {
        logic advance;
        logic clear;
        logic fold;
    } cell_ctrl_t;

    // One result item
    typedef struct packed {
        logic                 match_found;
        logic [OUT_COL_W-1:0] match_column;
        logic                 line_done;
        logic                 line_too_long;
    } result_t;

    // Fold ASCII A-Z to lower case when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/nsf_cell.sv]
`default_nettype none

module nsf_cell
    import nsf_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cell_ctrl_t                    ctrl,
    input  wire logic [LEN_W-1:0]              pattern_length,
    input  wire logic [MAX_PATTERN-1:0][7:0]   pattern,
    input  wire logic [7:0]                    data_in,
    output logic [7:0]                         data_out,
    output logic                               byte_ok
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]       data_reg;
    logic [7:0]       data_next;
    logic [LEN_W:0]   pat_pos;
    logic [IDX_W-1:0] pat_idx;
    logic             active;

    // This cell holds the byte INDEX+1 places behind the current one
    always_comb begin
        data_next = data_reg;
        if (ctrl.clear) begin
            data_next = 8'h00;
        end else if (ctrl.advance) begin
            data_next = data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= 8'h00;
        end else begin
            data_reg <= data_next;
        end
    end

    // Pattern byte aligned with this cell: index length-2-INDEX
    assign active  = {1'b0, pattern_length} > (LEN_W+1)'(INDEX + 1);
    assign pat_pos = {1'b0, pattern_length} - (LEN_W+1)'(INDEX + 2);
    assign pat_idx = pat_pos[IDX_W-1:0];

    assign byte_ok  = !active
                    || (fold_byte(data_reg, ctrl.fold) == fold_byte(pattern[pat_idx], ctrl.fold));
    assign data_out = data_reg;

endmodule

`default_nettype wire

[rtl/core/nonoverlapping_substring_finder.sv]
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------------------
// s_ (text) | in        | s_valid / s_ready  | s_text_byte[7:0], s_line_last
// m_ (hits) | out       | m_valid / m_ready  | m_match_found, m_match_column[15:0],
//           |           |                    | m_line_done, m_line_too_long
// APB cfg   | in/out    | psel/penable       | paddr[4:0], pwdata/prdata[63:0], pready
//
// One item per cycle while s_ready is high: the history cells compare in parallel against
// the pattern in the cycle an item is accepted; its result is registered in the output or skid slot.
// An output register plus a skid register decouple the channels, so input keeps flowing
// for one extra item while m_ready is low; s_ready drops only once the skid is full.
// aresetn is synchronous, active low: it clears the history, column state, config and
// the valid flags of the result slots. No clearing pass is needed.
module nonoverlapping_substring_finder
    import nsf_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // text input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_text_byte,
    input  wire logic              s_line_last,
    // match output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_match_found,
    output logic [OUT_COL_W-1:0]   m_match_column,
    output logic                   m_line_done,
    output logic                   m_line_too_long,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    // History cells: MAX_PATTERN-1 bytes behind the current one (at least one cell)
    localparam int CELLS = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // ---------------------------------------------------------------- configuration
    logic [LEN_W-1:0]  len_reg;
    logic [63:0]       pat_low_reg;
    logic [63:0]       pat_high_reg;
    logic              fold_reg;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            fold_reg     <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PATTERN_LENGTH: len_reg      <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH:   pat_high_reg <= pwdata;
                REG_IGNORE_CASE:    fold_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PATTERN_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, len_reg};
            REG_PATTERN_LOW:    prdata = pat_low_reg;
            REG_PATTERN_HIGH:   prdata = pat_high_reg;
            REG_IGNORE_CASE:    prdata = {{(APB_DW-1){1'b0}}, fold_reg};
            default:            prdata = '0;
        endcase
    end

    // Pattern bytes in order, byte 0 first
    logic [127:0]                    pat_all;
    logic [MAX_PATTERN-1:0][7:0]     pattern;

    assign pat_all = {pat_high_reg, pat_low_reg};

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pattern[i] = pat_all[8*i +: 8];
        end
    end

    // ---------------------------------------------------------------- handshake
    logic accept;
    logic take;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;

    // ---------------------------------------------------------------- history chain
    cell_ctrl_t                 cell_ctrl;
    logic [CELLS-1:0][7:0]      cell_data;
    logic [CELLS-1:0]           cell_ok;

    assign cell_ctrl.advance = accept;
    assign cell_ctrl.clear   = accept && s_line_last;
    assign cell_ctrl.fold    = fold_reg;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        nsf_cell #(
            .INDEX       (k),
            .MAX_PATTERN (MAX_PATTERN)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (cell_ctrl),
            .pattern_length (len_reg),
            .pattern        (pattern),
            .data_in        ((k == 0) ? s_text_byte : cell_data[(k == 0) ? 0 : k-1]),
            .data_out       (cell_data[k]),
            .byte_ok        (cell_ok[k])
        );
    end

    // ---------------------------------------------------------------- match decision
    logic [COLUMN_BITS-1:0] col_reg;
    logic [COLUMN_BITS-1:0] col_next;
    logic [COLUMN_BITS-1:0] next_start_reg;
    logic [COLUMN_BITS-1:0] next_start_next;
    logic                   ovf_reg;
    logic                   ovf_next;

    logic                   at_max;
    logic                   len_ok;
    logic [LEN_W-1:0]       len_m1;
    logic                   cur_ok;
    logic [COLUMN_BITS:0]   col_p1;
    logic [COLUMN_BITS:0]   start_wide;
    logic [COLUMN_BITS-1:0] start;
    logic [COLUMN_BITS+OUT_COL_W-1:0] start_ext;
    logic                   found;
    logic                   ovf_out;

    assign at_max     = &col_reg;
    assign len_ok     = (len_reg != '0) && ({1'b0, len_reg} <= (LEN_W+1)'(MAX_PATTERN));
    assign len_m1     = len_reg - LEN_W'(1);
    assign cur_ok     = fold_byte(s_text_byte, fold_reg)
                        == fold_byte(pattern[len_m1[IDX_W-1:0]], fold_reg);
    assign col_p1     = {1'b0, col_reg} + (COLUMN_BITS+1)'(1);
    assign start_wide = col_p1 - (COLUMN_BITS+1)'(len_reg);
    assign start      = start_wide[COLUMN_BITS-1:0];
    assign start_ext  = {{OUT_COL_W{1'b0}}, start};

    // A match needs a live line, a valid length, a full window, no overlap with the last hit, all bytes equal
    assign found = !at_max && !ovf_reg && len_ok
                && (col_p1 >= (COLUMN_BITS+1)'(len_reg))
                && (start >= next_start_reg)
                && cur_ok && (&cell_ok);
    assign ovf_out = ovf_reg || at_max;

    always_comb begin
        col_next        = col_reg;
        next_start_next = next_start_reg;
        ovf_next        = ovf_reg;
        if (accept) begin
            if (s_line_last) begin
                // drop all line state after the last byte
                col_next        = '0;
                next_start_next = '0;
                ovf_next        = 1'b0;
            end else begin
                ovf_next = ovf_out;
                if (!at_max) begin
                    col_next = col_p1[COLUMN_BITS-1:0];
                end
                if (found) begin
                    next_start_next = col_p1[COLUMN_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            next_start_reg <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            col_reg        <= col_next;
            next_start_reg <= next_start_next;
            ovf_reg        <= ovf_next;
        end
    end

    // ---------------------------------------------------------------- result slots
    result_t new_res;
    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;

    assign new_res.match_found   = found;
    assign new_res.match_column  = found ? start_ext[OUT_COL_W-1:0] : '0;
    assign new_res.line_done     = s_line_last;
    assign new_res.line_too_long = ovf_out;

    // Refill the output slot from the skid first, else from the new item; park in skid
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_next       = new_res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            skid_next       = new_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_match_found   = out_reg.match_found;
    assign m_match_column  = out_reg.match_column;
    assign m_line_done     = out_reg.line_done;
    assign m_line_too_long = out_reg.line_too_long;

    // ---------------------------------------------------------------- checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds an item while the output slot is empty");

    a_hit_not_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_found) |-> !m_line_too_long)
        else $error("match reported on a saturated line");

    a_line_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_line_last) |=> (col_reg == '0) && !ovf_reg && (next_start_reg == '0))
        else $error("line state not cleared after the last byte");

    a_start_behind_col: assert property (@(posedge aclk) disable iff (!aresetn)
        next_start_reg <= col_reg)
        else $error("next allowed start runs ahead of the column");

endmodule

`default_nettype wire
